// File: rtl/drd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drd_pkg: shared types and constants for the detection row decoder
// Row formats, register indexes, the row record handed from front to back
// and the detection record handed to the result queue.
// ---------------------------------------------------------------------------
package drd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_ROWS  = 65536;
  localparam logic [15:0] ROW_LAST = 16'(MAX_ROWS - 1);

  localparam logic [9:0] FIRST_CLASS_OBJ = 10'd5;
  localparam logic [9:0] FIRST_CLASS     = 10'd4;

  typedef enum logic [1:0] {
    FMT_OBJ_CENTER = 2'd0,
    FMT_CENTER     = 2'd1,
    FMT_CORNER     = 2'd2
  } row_fmt_t;

  typedef enum logic [2:0] {
    CFG_ROW_FORMAT   = 3'd0,
    CFG_CLASS_COUNT  = 3'd1,
    CFG_ROW_LENGTH   = 3'd2,
    CFG_CONF_THRESH  = 3'd3,
    CFG_SCORE_THRESH = 3'd4,
    CFG_IMAGE_WIDTH  = 3'd5,
    CFG_IMAGE_HEIGHT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  row_format;
    logic [9:0]  class_count;
    logic [9:0]  row_length;
    logic [16:0] conf_thresh;
    logic [16:0] score_thresh;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [3:0][31:0] box;
    logic [31:0]      obj;
    logic [31:0]      best;
    logic [9:0]       best_class;
    logic             class_valid;
    logic [15:0]      row;
  } row_rec_t;

  typedef struct packed {
    logic [15:0] box_index;
    logic [9:0]  cls_index;
    logic [30:0] det_score;
    logic [14:0] box_left;
    logic [14:0] box_top;
    logic [15:0] box_width;
    logic [15:0] box_height;
  } det_t;

endpackage

// File: rtl/detection_row_decode_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// detection_row_decode_core: streaming decoder for detector output rows
// Accumulates one row of Q16.16 values and emits at most one detection.
// ---------------------------------------------------------------------------
// Usage
//   Input queue: drive in_sample_value / in_frame_start with in_push; the
//   value transfers on a clock edge with in_push high and in_full low. Raise
//   in_frame_start on element 0 of row 0 of each frame.
//   Result queue: while out_empty is low the oldest detection sits on the
//   out_ ports; it transfers on an edge with out_pop high.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_index at the
//   edge; write only while the block is idle.
//   Throughput: one value per cycle, sustained indefinitely while results
//   are drained; a row yields at most one result.
//   Path: the result of a row is registered in turn in the row queue, the
//   product stage, the threshold/clamp stage and the result queue before
//   it appears on the out_ ports.
//   Stall: a full result queue (4 entries) holds the evaluation pipeline,
//   the 4-entry row queue then fills and in_full rises.
//   Reset: registers return to defaults, counters and queues clear.
// ---------------------------------------------------------------------------
module detection_row_decode_core (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_sample_value,
  input  logic               in_frame_start,

  output logic               out_empty,
  input  logic               out_pop,
  output logic [15:0]        out_box_index,
  output logic [9:0]         out_cls_index,
  output logic [30:0]        out_det_score,
  output logic [14:0]        out_box_left,
  output logic [14:0]        out_box_top,
  output logic signed [15:0] out_box_width,
  output logic signed [15:0] out_box_height,

  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  import drd_pkg::*;

  localparam int QDEPTH = 4;

  cfg_t     cfg_r;
  logic     accept;
  logic     rec_push, rec_full, rec_empty, rec_pop;
  row_rec_t rec_in, rec_out;
  logic     det_push, det_full;
  det_t     det_in, det_out;

  // Register file: fields written straight from the data bus.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_format   <= FMT_CENTER;
      cfg_r.class_count  <= 10'd80;
      cfg_r.row_length   <= 10'd84;
      cfg_r.conf_thresh  <= 17'd16384;
      cfg_r.score_thresh <= 17'd16384;
      cfg_r.image_width  <= 13'd640;
      cfg_r.image_height <= 13'd640;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROW_FORMAT:   cfg_r.row_format   <= cfg_data[1:0];
        CFG_CLASS_COUNT:  cfg_r.class_count  <= cfg_data[9:0];
        CFG_ROW_LENGTH:   cfg_r.row_length   <= cfg_data[9:0];
        CFG_CONF_THRESH:  cfg_r.conf_thresh  <= cfg_data;
        CFG_SCORE_THRESH: cfg_r.score_thresh <= cfg_data;
        CFG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[12:0];
        CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Take a value only when the row queue has room, so a row end never drops.
  assign in_full = rec_full;
  assign accept  = in_push && !rec_full;

  drd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .accept       (accept),
    .sample_value (in_sample_value),
    .frame_start  (in_frame_start),
    .rec_push     (rec_push),
    .rec          (rec_in)
  );

  drd_fifo #(
    .WIDTH ($bits(row_rec_t)),
    .DEPTH (QDEPTH)
  ) u_row_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .wdata (rec_in),
    .full  (rec_full),
    .pop   (rec_pop),
    .rdata (rec_out),
    .empty (rec_empty)
  );

  drd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec       (rec_out),
    .rec_empty (rec_empty),
    .rec_pop   (rec_pop),
    .det_push  (det_push),
    .det       (det_in),
    .det_full  (det_full)
  );

  drd_fifo #(
    .WIDTH ($bits(det_t)),
    .DEPTH (QDEPTH)
  ) u_det_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (det_push),
    .wdata (det_in),
    .full  (det_full),
    .pop   (out_pop),
    .rdata (det_out),
    .empty (out_empty)
  );

  assign out_box_index  = det_out.box_index;
  assign out_cls_index  = det_out.cls_index;
  assign out_det_score  = det_out.det_score;
  assign out_box_left   = det_out.box_left;
  assign out_box_top    = det_out.box_top;
  assign out_box_width  = $signed(det_out.box_width);
  assign out_box_height = $signed(det_out.box_height);

endmodule

// File: rtl/drd_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drd_fifo: small show-ahead queue
// Register array with read and write pointers; head entry is always visible.
// ---------------------------------------------------------------------------
module drd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage, no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/drd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drd_front: row accumulator
// Track the element position, capture box and objectness values, keep the
// running class argmax and hand a row record to the back end at row end.
// ---------------------------------------------------------------------------
module drd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  drd_pkg::cfg_t       cfg,
  input  logic                accept,
  input  logic signed [31:0]  sample_value,
  input  logic                frame_start,
  output logic                rec_push,
  output drd_pkg::row_rec_t   rec
);

  import drd_pkg::*;

  logic [9:0]       pos_r, pos_nxt;
  logic [15:0]      row_r, row_nxt;
  logic             cv_r, cv_nxt;
  logic [9:0]       best_class_r, best_class_nxt;
  logic [31:0]      best_r, best_nxt;
  logic [31:0]      obj_r, obj_nxt;
  logic [3:0][31:0] box_r, box_nxt;

  logic       with_obj;
  logic [9:0] first_cls;
  logic [9:0] p;
  logic [15:0] row_cur;
  logic       cv_cur;
  logic [9:0] cls_idx;
  logic       is_class;
  logic       take;
  logic       row_end;

  always_comb begin
    with_obj  = (cfg.row_format == FMT_OBJ_CENTER);
    first_cls = with_obj ? FIRST_CLASS_OBJ : FIRST_CLASS;
    p         = frame_start ? '0 : pos_r;
    row_cur   = frame_start ? '0 : row_r;
    cv_cur    = frame_start ? 1'b0 : cv_r;
    cls_idx   = p - first_cls;
    is_class  = (p >= first_cls) && (cls_idx < cfg.class_count);
    take      = is_class && (!cv_cur || ($signed(sample_value) > $signed(best_r)));
    row_end   = ({1'b0, p} + 11'd1) >= {1'b0, cfg.row_length};

    box_nxt        = box_r;
    obj_nxt        = obj_r;
    best_nxt       = best_r;
    best_class_nxt = best_class_r;
    cv_nxt         = cv_r;
    pos_nxt        = pos_r;
    row_nxt        = row_r;

    if (accept) begin
      if (p < 10'd4) begin
        box_nxt[p[1:0]] = sample_value;
      end else if (with_obj && p == 10'd4) begin
        obj_nxt = sample_value;
      end
      cv_nxt = cv_cur;
      if (take) begin
        best_nxt       = sample_value;
        best_class_nxt = cls_idx;
        cv_nxt         = 1'b1;
      end
      if (row_end) begin
        pos_nxt = '0;
        row_nxt = (row_cur == ROW_LAST) ? '0 : row_cur + 16'd1;
      end else begin
        pos_nxt = p + 10'd1;
        row_nxt = row_cur;
      end
    end

    rec_push         = accept && row_end;
    rec.box          = box_nxt;
    rec.obj          = obj_nxt;
    rec.best         = best_nxt;
    rec.best_class   = best_class_nxt;
    rec.class_valid  = cv_nxt;
    rec.row          = row_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      row_r        <= '0;
      cv_r         <= 1'b0;
      best_class_r <= '0;
    end else begin
      pos_r        <= pos_nxt;
      row_r        <= row_nxt;
      cv_r         <= (accept && row_end) ? 1'b0 : cv_nxt;
      best_class_r <= best_class_nxt;
    end
  end

  always_ff @(posedge clk) begin
    box_r  <= box_nxt;
    obj_r  <= obj_nxt;
    best_r <= best_nxt;
  end

endmodule

// File: rtl/drd_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drd_back: row evaluation pipeline
// Stage one forms the score product and the raw box; stage two saturates the
// score, applies the thresholds and clamps the box; clipping feeds the queue.
// ---------------------------------------------------------------------------
module drd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  drd_pkg::cfg_t     cfg,
  input  drd_pkg::row_rec_t rec,
  input  logic              rec_empty,
  output logic              rec_pop,
  output logic              det_push,
  output drd_pkg::det_t     det,
  input  logic              det_full
);

  import drd_pkg::*;

  function automatic logic signed [17:0] trunc_box(input logic signed [34:0] v,
                                                   input logic [4:0] sh);
    logic signed [34:0] bias;
    logic signed [34:0] t;
    bias = v[34] ? ((35'sd1 <<< sh) - 35'sd1) : 35'sd0;
    t    = (v + bias) >>> sh;
    return t[17:0];
  endfunction

  function automatic logic [14:0] clamp_pos(input logic signed [17:0] v);
    if (v < 18'sd0) begin
      return 15'd0;
    end else if (v > 18'sd32767) begin
      return 15'h7FFF;
    end
    return v[14:0];
  endfunction

  function automatic logic [15:0] clip_size(input logic [14:0] c, input logic [14:0] s,
                                            input logic [12:0] ext);
    logic [15:0] sum;
    sum = {1'b0, c} + {1'b0, s};
    if (sum < {3'b0, ext}) begin
      return {1'b0, s};
    end
    return {3'b0, ext} - {1'b0, c};
  endfunction

  localparam logic [4:0] SH  = 5'(FRAC_BITS);
  localparam logic [4:0] SH1 = 5'(FRAC_BITS + 1);

  logic adv;

  // stage one
  logic               s1_v_r;
  logic signed [63:0] s1_prod_r;
  logic [31:0]        s1_best_r;
  logic [9:0]         s1_class_r;
  logic [15:0]        s1_row_r;
  logic               s1_ok_r;
  logic               s1_obj_r;
  logic signed [17:0] s1_left_r, s1_top_r, s1_w_r, s1_h_r;

  // stage two
  logic               s2_v_r;
  logic               s2_pass_r;
  logic [30:0]        s2_score_r;
  logic [9:0]         s2_class_r;
  logic [15:0]        s2_row_r;
  logic [14:0]        s2_left_r, s2_top_r, s2_w_r, s2_h_r;

  logic               with_obj, corner, obj_ok;
  logic signed [31:0] b0, b1, b2, b3;
  logic signed [17:0] left_raw, top_raw, w_raw, h_raw;
  logic signed [63:0] prod_bias, prod_q;
  logic signed [31:0] score;
  logic               score_ok;

  // Hold the pipeline only when a passing result cannot enter the queue.
  assign adv      = !(s2_v_r && s2_pass_r && det_full);
  assign rec_pop  = adv && !rec_empty;
  assign det_push = s2_v_r && s2_pass_r && !det_full;

  always_comb begin
    with_obj = (cfg.row_format == FMT_OBJ_CENTER);
    corner   = (cfg.row_format == FMT_CORNER);
    b0 = $signed(rec.box[0]);
    b1 = $signed(rec.box[1]);
    b2 = $signed(rec.box[2]);
    b3 = $signed(rec.box[3]);
    obj_ok = !with_obj ||
             ($signed({rec.obj[31], rec.obj}) >= $signed({16'b0, cfg.conf_thresh}));
    if (corner) begin
      left_raw = trunc_box({{3{b0[31]}}, b0}, SH);
      top_raw  = trunc_box({{3{b1[31]}}, b1}, SH);
      w_raw    = trunc_box({{3{b2[31]}}, b2} - {{3{b0[31]}}, b0}, SH);
      h_raw    = trunc_box({{3{b3[31]}}, b3} - {{3{b1[31]}}, b1}, SH);
    end else begin
      left_raw = trunc_box({{2{b0[31]}}, b0, 1'b0} - {{3{b2[31]}}, b2}, SH1);
      top_raw  = trunc_box({{2{b1[31]}}, b1, 1'b0} - {{3{b3[31]}}, b3}, SH1);
      w_raw    = trunc_box({{3{b2[31]}}, b2}, SH);
      h_raw    = trunc_box({{3{b3[31]}}, b3}, SH);
    end
  end

  always_comb begin
    prod_bias = s1_prod_r[63] ? ((64'sd1 <<< SH) - 64'sd1) : 64'sd0;
    prod_q    = (s1_prod_r + prod_bias) >>> SH;
    if (!s1_obj_r) begin
      score = $signed(s1_best_r);
    end else if (prod_q > 64'sh7FFFFFFF) begin
      score = 32'sh7FFFFFFF;
    end else if (prod_q < $signed(64'hFFFFFFFF80000000)) begin
      score = $signed(32'h80000000);
    end else begin
      score = prod_q[31:0];
    end
    score_ok = ($signed({score[31], score}) >= $signed({16'b0, cfg.score_thresh}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= !rec_empty;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r  <= $signed(rec.best) * $signed(rec.obj);
      s1_best_r  <= rec.best;
      s1_class_r <= rec.best_class;
      s1_row_r   <= rec.row;
      s1_ok_r    <= rec.class_valid && obj_ok;
      s1_obj_r   <= with_obj;
      s1_left_r  <= left_raw;
      s1_top_r   <= top_raw;
      s1_w_r     <= w_raw;
      s1_h_r     <= h_raw;

      s2_pass_r  <= s1_ok_r && score_ok;
      s2_score_r <= score[30:0];
      s2_class_r <= s1_class_r;
      s2_row_r   <= s1_row_r;
      s2_left_r  <= clamp_pos(s1_left_r);
      s2_top_r   <= clamp_pos(s1_top_r);
      s2_w_r     <= clamp_pos(s1_w_r);
      s2_h_r     <= clamp_pos(s1_h_r);
    end
  end

  always_comb begin
    det.box_index  = s2_row_r;
    det.cls_index  = s2_class_r;
    det.det_score  = s2_score_r;
    det.box_left   = s2_left_r;
    det.box_top    = s2_top_r;
    det.box_width  = clip_size(s2_left_r, s2_w_r, cfg.image_width);
    det.box_height = clip_size(s2_top_r, s2_h_r, cfg.image_height);
  end

endmodule

// File: dv/tb_detection_row_decode_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_detection_row_decode_core: self-checking bench for the row decoder
// Streams detector rows into the input queue, predicts each detection from a
// bit-exact model of the row decode kept in the bench, and checks every
// transfer from the result queue field by field against the oldest
// prediction. Directed rows cover the value extremes, every row format, the
// threshold edges and short rows; random phases then vary the registers,
// the row shapes and the idling on both queues.
// ---------------------------------------------------------------------------
module tb_detection_row_decode_core;
  import drd_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;     // margin for the pipeline to settle
  localparam int DRAIN_LIMIT   = 5000;
  localparam int RANDOM_VALUES = 1600;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic signed [31:0] in_sample_value;
  logic               in_frame_start;
  logic               out_empty;
  logic               out_pop;
  logic [15:0]        out_box_index;
  logic [9:0]         out_cls_index;
  logic [30:0]        out_det_score;
  logic [14:0]        out_box_left;
  logic [14:0]        out_box_top;
  logic signed [15:0] out_box_width;
  logic signed [15:0] out_box_height;
  logic               cfg_wr_en;
  logic [2:0]         cfg_index;
  logic [16:0]        cfg_data;

  detection_row_decode_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_sample_value(in_sample_value),
    .in_frame_start (in_frame_start),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_box_index  (out_box_index),
    .out_cls_index  (out_cls_index),
    .out_det_score  (out_det_score),
    .out_box_left   (out_box_left),
    .out_box_top    (out_box_top),
    .out_box_width  (out_box_width),
    .out_box_height (out_box_height),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Register shadow, starting from the reset defaults.
  logic [1:0] m_fmt      = FMT_CENTER;
  int         m_classes  = 80;
  int         m_row_len  = 84;
  int         m_conf     = 16384;
  int         m_score_th = 16384;
  int         m_img_w    = 640;
  int         m_img_h    = 640;

  // Row accumulator shadow.
  logic [9:0]  elem_pos   = '0;
  logic [15:0] row_num    = '0;
  longint      box_q[4];
  longint      obj_val;
  longint      best_val;
  logic [9:0]  best_cls   = '0;
  logic        have_class = 1'b0;

  det_t        pending_dets[$];
  int          fault_count   = 0;
  int          cycle_count   = 0;
  bit          src_mode      = 1'b0;  // 1: random gaps between input transfers
  bit          sink_mode     = 1'b0;  // 1: random stalls on the result side
  int          sink_hold     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Row decode prediction
  // -------------------------------------------------------------------------

  // Divide by 2^s, rounding toward zero.
  function automatic longint shr_tz(input longint v, input int s);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = mag >> s;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Clamp corner and size along one axis, then cut the size at the image
  // edge; returns {corner[14:0], size[15:0]}.
  function automatic logic [30:0] clip_span(input longint corner, input longint size,
                                            input int extent);
    longint c;
    longint s;
    c = saturate(corner, 0, 32767);
    s = saturate(size, 0, 32767);
    if (!(c + s < longint'(extent))) s = longint'(extent) - c;
    return {c[14:0], s[15:0]};
  endfunction

  // Advance the row shadow by one accepted value; queue the detection that
  // the value completes, if any.
  function automatic void decode_sample(input logic [31:0] word, input logic fs);
    longint      val;
    longint      score;
    longint      left;
    longint      top;
    longint      wd;
    longint      ht;
    int unsigned p;
    int unsigned base;
    logic        with_obj;
    logic        is_corner;
    logic        keep;
    det_t        d;
    val       = longint'($signed(word));
    with_obj  = (m_fmt == FMT_OBJ_CENTER);
    is_corner = (m_fmt == FMT_CORNER);
    base      = with_obj ? 32'(FIRST_CLASS_OBJ) : 32'(FIRST_CLASS);
    if (fs) begin
      elem_pos   = '0;
      row_num    = '0;
      have_class = 1'b0;
    end
    p = 32'(elem_pos);
    if (p < 4) box_q[p] = val;
    else if (with_obj && p == 4) obj_val = val;
    // first maximum wins: replace only on a strictly greater score
    if (p >= base && p - base < m_classes) begin
      if (!have_class || val > best_val) begin
        best_val   = val;
        best_cls   = 10'(p - base);
        have_class = 1'b1;
      end
    end
    if (p + 1 >= m_row_len) begin
      keep  = have_class;
      score = best_val;
      if (keep && with_obj) begin
        if (obj_val < m_conf) keep = 1'b0;
        score = saturate(shr_tz(best_val * obj_val, FRAC_BITS),
                         -64'sd2147483648, 64'sd2147483647);
      end
      if (keep && score < m_score_th) keep = 1'b0;
      if (keep) begin
        if (is_corner) begin
          left = shr_tz(box_q[0], FRAC_BITS);
          top  = shr_tz(box_q[1], FRAC_BITS);
          wd   = shr_tz(box_q[2] - box_q[0], FRAC_BITS);
          ht   = shr_tz(box_q[3] - box_q[1], FRAC_BITS);
        end else begin
          // centre minus half size, kept exact with one more fraction bit
          left = shr_tz(2 * box_q[0] - box_q[2], FRAC_BITS + 1);
          top  = shr_tz(2 * box_q[1] - box_q[3], FRAC_BITS + 1);
          wd   = shr_tz(box_q[2], FRAC_BITS);
          ht   = shr_tz(box_q[3], FRAC_BITS);
        end
        d.box_index = row_num;
        d.cls_index = best_cls;
        d.det_score = score[30:0];
        {d.box_left, d.box_width} = clip_span(left, wd, m_img_w);
        {d.box_top, d.box_height} = clip_span(top, ht, m_img_h);
        pending_dets.insert(pending_dets.size(), d);
      end
      row_num    = row_num + 16'd1;
      elem_pos   = '0;
      have_class = 1'b0;
    end else begin
      elem_pos = 10'(p + 1);
    end
  endfunction

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Q16.16 coordinate in a plausible pixel range, a little below zero too.
  function automatic logic [31:0] draw_pixel();
    return $urandom_range(0, 32'd900 << 16) - (32'd100 << 16);
  endfunction

  // Send one value; called and returns at a falling edge, push left high so
  // back-to-back transfers need no extra edge.
  task automatic push_sample(input logic [31:0] word, input logic fs);
    int gap;
    gap = src_mode ? draw_gap() : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push         <= 1'b1;
    in_sample_value <= word;
    in_frame_start  <= fs;
    do @(posedge clk); while (in_full);
    decode_sample(word, fs);
    @(negedge clk);
  endtask

  task automatic push_row(input logic [31:0] vals[$], input logic fs);
    foreach (vals[i]) push_sample(vals[i], fs && i == 0);
  endtask

  // Hold the input side until every predicted detection has transferred,
  // then let the pipeline settle.
  task automatic wait_idle();
    int n;
    n = 0;
    in_push <= 1'b0;
    while (pending_dets.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[16:0];
    @(posedge clk);
    case (idx)
      CFG_ROW_FORMAT:   m_fmt      = value[1:0];
      CFG_CLASS_COUNT:  m_classes  = int'(value[9:0]);
      CFG_ROW_LENGTH:   m_row_len  = int'(value[9:0]);
      CFG_CONF_THRESH:  m_conf     = int'(value[16:0]);
      CFG_SCORE_THRESH: m_score_th = int'(value[16:0]);
      CFG_IMAGE_WIDTH:  m_img_w    = int'(value[12:0]);
      CFG_IMAGE_HEIGHT: m_img_h    = int'(value[12:0]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Rewrite every register; only while idle.
  task automatic program_regs(input int fmt, input int classes, input int row_len,
                              input int conf, input int score_th,
                              input int img_w, input int img_h);
    write_reg(CFG_ROW_FORMAT, fmt);
    write_reg(CFG_CLASS_COUNT, classes);
    write_reg(CFG_ROW_LENGTH, row_len);
    write_reg(CFG_CONF_THRESH, conf);
    write_reg(CFG_SCORE_THRESH, score_th);
    write_reg(CFG_IMAGE_WIDTH, img_w);
    write_reg(CFG_IMAGE_HEIGHT, img_h);
    cfg_wr_en <= 1'b0;
  endtask

  // Result side: pop freely, or stall at random for short and long spells.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_pop <= 1'b0;
        sink_hold--;
      end else begin
        out_pop <= 1'b1;
        if (sink_mode && $urandom_range(0, 9) == 0)
          sink_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                  : $urandom_range(10, 60);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result checking
  // -------------------------------------------------------------------------

  function automatic void match(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    det_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_dets.size() == 0) begin
        $error("detection for row %0d with none predicted", out_box_index);
        fault_count++;
      end else begin
        want = pending_dets.pop_front();
        match("box_index", want.box_index, out_box_index);
        match("cls_index", want.cls_index, out_cls_index);
        match("det_score", want.det_score, out_det_score);
        match("box_left", want.box_left, out_box_left);
        match("box_top", want.box_top, out_box_top);
        match("box_width", $signed(want.box_width), out_box_width);
        match("box_height", $signed(want.box_height), out_box_height);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Corner boxes at the 32-bit limits: corners and sizes saturate, height goes
  // negative against the image; a most-negative score drops the second row.
  task automatic test_corner_extremes();
    logic [31:0] row_q[$];
    wait_idle();
    src_mode  = 1'b1;
    sink_mode = 1'b1;
    program_regs(FMT_CORNER, 1, 5, 0, 0, 8191, 8191);
    row_q = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    push_row(row_q, 1'b1);
    row_q = '{32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    push_row(row_q, 1'b0);
  endtask

  // Unused format code decodes as centre boxes; score exactly at threshold
  // passes, one LSB below is dropped; a one-pixel image clips the width to 1.
  task automatic test_center_thresholds();
    logic [31:0] row_q[$];
    wait_idle();
    program_regs(3, 1, 5, 0, 32'h0001_0000, 1, 8191);
    row_q = '{32'h0064_8000, 32'h0032_0000, 32'h00C8_0000, 32'h0064_0000, 32'h0001_0000};
    push_row(row_q, 1'b1);
    row_q = '{32'h0064_8000, 32'h0032_0000, 32'h00C8_0000, 32'h0064_0000, 32'h0000_FFFF};
    push_row(row_q, 1'b0);
  endtask

  // Objectness times class score saturates; tied class scores keep the first;
  // the trailing extra value is ignored; both thresholds at 1.0 (65536).
  task automatic test_objectness_saturation();
    logic [31:0] row_q[$];
    wait_idle();
    src_mode  = 1'b0;
    sink_mode = 1'b0;
    program_regs(FMT_OBJ_CENTER, 2, 8, 65536, 65536, 640, 640);
    row_q = '{32'h0140_0000, 32'h00F0_0000, 32'h0050_0000, 32'h0040_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    push_row(row_q, 1'b1);
  endtask

  // Rows that end before any class score, or carry no class at all, emit
  // nothing but still advance the row number seen by the next detection.
  task automatic test_short_rows();
    logic [31:0] row_q[$];
    wait_idle();
    src_mode = 1'b1;
    program_regs(FMT_CENTER, 1, 0, 0, 0, 640, 640);
    row_q = '{32'h0010_0000, 32'h0020_0000};
    push_row(row_q, 1'b1);
    wait_idle();
    program_regs(FMT_CENTER, 0, 5, 0, 0, 640, 640);
    row_q = '{32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 32'h0040_0000, 32'h0001_0000};
    push_row(row_q, 1'b0);
    wait_idle();
    program_regs(FMT_CENTER, 1, 5, 0, 0, 640, 640);
    push_row(row_q, 1'b0);
  endtask

  // Random phases: registers redrawn per phase, mostly whole rows with random
  // content, some frames restarted and some rows cut short.
  task automatic test_random_rows();
    int          sent;
    int          r;
    int          fmt;
    int          classes;
    int          row_len;
    int          eff_len;
    int          base;
    int          rows;
    int          cut;
    logic        fs;
    logic [31:0] word;
    logic [31:0] last_score;
    sent       = 0;
    last_score = '0;
    while (sent < RANDOM_VALUES) begin
      wait_idle();
      r   = $urandom_range(0, 9);
      fmt = (r < 3) ? FMT_OBJ_CENTER : (r < 6) ? FMT_CENTER : (r < 9) ? FMT_CORNER : 3;
      base = (fmt == FMT_OBJ_CENTER) ? 5 : 4;
      r = $urandom_range(0, 99);
      classes = (r < 3) ? 1023 : (r < 7) ? 0 : (r < 80) ? $urandom_range(1, 6)
                                                         : $urandom_range(7, 60);
      row_len = base + classes + $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) row_len = $urandom_range(0, base + classes);
      if (row_len > 1023) row_len = 1023;
      r = $urandom_range(0, 19);
      program_regs(fmt, classes, row_len,
                   (r < 2) ? 0 : (r < 4) ? 65536 : (r < 5) ? $urandom_range(65537, 131071)
                                                           : $urandom_range(0, 'hC000),
                   (r == 7) ? 0 : (r == 8) ? 65536 : (r == 9) ? $urandom_range(65537, 131071)
                                                             : $urandom_range(0, 'h9000),
                   ($urandom_range(0, 9) == 0) ? 1 : ($urandom_range(0, 9) == 0) ? 8191
                     : ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 8191),
                   ($urandom_range(0, 9) == 0) ? 1 : ($urandom_range(0, 9) == 0) ? 8191
                     : ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 8191));
      src_mode  = ($urandom_range(0, 3) != 0);
      sink_mode = ($urandom_range(0, 3) != 0);
      eff_len   = (row_len == 0) ? 1 : row_len;
      rows      = (eff_len >= 200) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      fs        = 1'b1;
      repeat (rows) begin
        if (sent >= RANDOM_VALUES) break;
        // now and then stop a row early and restart the frame behind it
        cut = (eff_len > 1 && $urandom_range(0, 49) == 0) ? $urandom_range(1, eff_len - 1)
                                                          : eff_len;
        if (!fs && $urandom_range(0, 19) == 0) fs = 1'b1;
        for (int j = 0; j < cut; j++) begin
          if (j < 4) begin
            word = ($urandom_range(0, 3) != 0) ? draw_pixel() : $urandom;
          end else if (fmt == FMT_OBJ_CENTER && j == 4) begin
            word = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 'h10000) : $urandom;
          end else if (j >= base && j - base < classes) begin
            r    = $urandom_range(0, 19);
            word = (r < 3) ? last_score : (r < 16) ? $urandom_range(0, 'h10000) : $urandom;
            last_score = word;
          end else begin
            word = $urandom;
          end
          push_sample(word, fs && j == 0);
          sent++;
        end
        fs = (cut != eff_len);
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_sample_value = '0;
    in_frame_start  = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_ROW_FORMAT;
    cfg_data        = '0;
    foreach (box_q[i]) box_q[i] = 0;
    obj_val  = 0;
    best_val = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_extremes();
    test_center_thresholds();
    test_objectness_saturation();
    test_short_rows();
    test_random_rows();

    wait_idle();
    if (pending_dets.size() != 0) begin
      $error("%0d predicted detections never transferred", pending_dets.size());
      fault_count++;
    end
    if (fault_count == 0) $display("[detection_row_decode_core] OK");
    else $display("[detection_row_decode_core] ERROR");
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("[detection_row_decode_core] ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/drd_pkg.sv
rtl/drd_fifo.sv
rtl/drd_front.sv
rtl/drd_back.sv
rtl/detection_row_decode_core.sv
dv/tb_detection_row_decode_core.sv
